>>> rtl/ptc_pkg.sv
package ptc_pkg;

    localparam int QBITS = 36;
    localparam int DBITS = 41;
    localparam int NBITS = 76;
    localparam logic [11:0] PR_SCALE = 12'd3125;

    localparam logic [1:0] REG_TEMP_CAL = 2'd0;
    localparam logic [1:0] REG_CAL_A    = 2'd1;
    localparam logic [1:0] REG_CAL_B    = 2'd2;
    localparam logic [1:0] REG_CAL_C    = 2'd3;

    typedef struct packed {
        logic [19:0] raw_temperature;
        logic [19:0] raw_pressure;
    } t_in_item;

    typedef struct packed {
        logic signed [15:0] temperature_centi;
        logic signed [31:0] fine_temperature;
        logic [31:0]        pressure_q24_8;
        logic               pressure_valid;
    } t_out_item;

    typedef struct packed {
        logic               vld;
        logic [DBITS-1:0]   rem;
        logic [QBITS-1:0]   nlow;
        logic [QBITS-1:0]   quo;
        logic [DBITS-1:0]   dmag;
        logic               neg;
        logic               zero;
        logic               ovf;
        logic signed [15:0] tc;
        logic signed [31:0] fine;
    } t_div_slot;

endpackage

>>> rtl/pressure_temperature_compensation_core.sv
// Channel   Direction  Handshake                  Payload
// item      in         start, busy                i_item (raw temperature, raw pressure)
// result    out        o_done strobe              o_item (temperature, fine, pressure, valid)
// config    in         psel, penable, pwrite      paddr, pwdata, prdata (64-bit data bus)
// One transfer is accepted per cycle; busy is never raised.
// A result appears after its transfer has passed a 13-stage multiply front end,
// a row of 36 one-bit divider cells and a 4-stage pressure back end.
// Reset clears the calibration registers and all stage valid flags.
// The receiver cannot stall, so nothing in the pipeline ever waits.
module pressure_temperature_compensation_core (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                start,
    output logic                busy,
    input  ptc_pkg::t_in_item   i_item,
    output logic                o_done,
    output ptc_pkg::t_out_item  o_item,
    input  logic                psel,
    input  logic                penable,
    input  logic                pwrite,
    input  logic [4:0]          paddr,
    input  logic [63:0]         pwdata,
    output logic [63:0]         prdata,
    output logic                pready
);

    localparam int LAT = 13 + ptc_pkg::QBITS + 4;

    logic [47:0] r_temp_cal;
    logic [63:0] r_cal_a;
    logic [63:0] r_cal_b;
    logic [15:0] r_cal_c;

    logic [15:0]        w_t1;
    logic signed [15:0] w_t2, w_t3;
    logic [15:0]        w_p1;
    logic signed [15:0] w_p2, w_p3, w_p4, w_p5, w_p6, w_p7, w_p8, w_p9;

    assign pready = 1'b1;
    assign busy   = 1'b0;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_temp_cal <= '0;
            r_cal_a    <= '0;
            r_cal_b    <= '0;
            r_cal_c    <= '0;
        end else if (psel && penable && pwrite && pready) begin
            case (paddr[4:3])
                ptc_pkg::REG_TEMP_CAL: r_temp_cal <= pwdata[47:0];
                ptc_pkg::REG_CAL_A:    r_cal_a    <= pwdata;
                ptc_pkg::REG_CAL_B:    r_cal_b    <= pwdata;
                ptc_pkg::REG_CAL_C:    r_cal_c    <= pwdata[15:0];
                default: ;
            endcase
        end
    end

    always_comb begin
        case (paddr[4:3])
            ptc_pkg::REG_TEMP_CAL: prdata = {16'd0, r_temp_cal};
            ptc_pkg::REG_CAL_A:    prdata = r_cal_a;
            ptc_pkg::REG_CAL_B:    prdata = r_cal_b;
            ptc_pkg::REG_CAL_C:    prdata = {48'd0, r_cal_c};
            default:               prdata = '0;
        endcase
    end

    assign w_t1 = r_temp_cal[15:0];
    assign w_t2 = $signed(r_temp_cal[31:16]);
    assign w_t3 = $signed(r_temp_cal[47:32]);
    assign w_p1 = r_cal_a[15:0];
    assign w_p2 = $signed(r_cal_a[31:16]);
    assign w_p3 = $signed(r_cal_a[47:32]);
    assign w_p4 = $signed(r_cal_a[63:48]);
    assign w_p5 = $signed(r_cal_b[15:0]);
    assign w_p6 = $signed(r_cal_b[31:16]);
    assign w_p7 = $signed(r_cal_b[47:32]);
    assign w_p8 = $signed(r_cal_b[63:48]);
    assign w_p9 = $signed(r_cal_c);

    logic [11:0] r_sv;

    // Temperature front end.
    logic signed [17:0] w_x;
    logic signed [33:0] r_s1_ta;
    logic signed [16:0] r_s1_dt;
    logic [19:0]        r_s1_adcp;

    assign w_x = $signed({1'b0, i_item.raw_temperature[19:3]}) - $signed({1'b0, w_t1, 1'b0});

    always_ff @(posedge i_clk) begin
        r_s1_ta   <= w_x * w_t2;
        r_s1_dt   <= $signed({1'b0, i_item.raw_temperature[19:4]}) - $signed({1'b0, w_t1});
        r_s1_adcp <= i_item.raw_pressure;
    end

    logic signed [33:0] w_dtsq;
    logic signed [22:0] r_s2_at;
    logic [31:0]        r_s2_sq;
    logic [19:0]        r_s2_adcp;

    assign w_dtsq = r_s1_dt * r_s1_dt;

    always_ff @(posedge i_clk) begin
        r_s2_at   <= r_s1_ta[33:11];
        r_s2_sq   <= w_dtsq[31:0];
        r_s2_adcp <= r_s1_adcp;
    end

    logic signed [36:0] r_s3_tb;
    logic signed [22:0] r_s3_at;
    logic [19:0]        r_s3_adcp;

    always_ff @(posedge i_clk) begin
        r_s3_tb   <= $signed({1'b0, r_s2_sq[31:12]}) * w_t3;
        r_s3_at   <= r_s2_at;
        r_s3_adcp <= r_s2_adcp;
    end

    logic signed [31:0] r_s4_fine;
    logic [19:0]        r_s4_adcp;

    always_ff @(posedge i_clk) begin
        r_s4_fine <= 32'(r_s3_at) + 32'($signed(r_s3_tb[36:14]));
        r_s4_adcp <= r_s3_adcp;
    end

    logic signed [35:0] w_tc_full;
    logic signed [27:0] w_tc_sh;
    logic signed [15:0] w_tc_sat;
    logic signed [24:0] r_s5_pa;
    logic signed [15:0] r_s5_tc;
    logic signed [31:0] r_s5_fine;
    logic [19:0]        r_s5_adcp;

    assign w_tc_full = 36'(r_s4_fine) * 36'sd5 + 36'sd128;
    assign w_tc_sh   = w_tc_full[35:8];

    always_comb begin
        if (w_tc_sh > 28'sd32767) begin
            w_tc_sat = 16'sh7fff;
        end else if (w_tc_sh < -28'sd32768) begin
            w_tc_sat = 16'sh8000;
        end else begin
            w_tc_sat = w_tc_sh[15:0];
        end
    end

    always_ff @(posedge i_clk) begin
        r_s5_pa   <= 25'(r_s4_fine) - 25'sd128000;
        r_s5_tc   <= w_tc_sat;
        r_s5_fine <= r_s4_fine;
        r_s5_adcp <= r_s4_adcp;
    end

    // Pressure divisor and numerator.
    logic signed [49:0] w_aa;
    logic [47:0]        r_s6_aa;
    logic signed [40:0] r_s6_ap5, r_s6_ap2;
    logic signed [15:0] r_s6_tc;
    logic signed [31:0] r_s6_fine;
    logic [19:0]        r_s6_adcp;

    assign w_aa = r_s5_pa * r_s5_pa;

    always_ff @(posedge i_clk) begin
        r_s6_aa   <= w_aa[47:0];
        r_s6_ap5  <= r_s5_pa * w_p5;
        r_s6_ap2  <= r_s5_pa * w_p2;
        r_s6_tc   <= r_s5_tc;
        r_s6_fine <= r_s5_fine;
        r_s6_adcp <= r_s5_adcp;
    end

    logic signed [64:0] w_aap6, w_aap3;
    logic signed [63:0] r_s7_aap6, r_s7_aap3;
    logic signed [40:0] r_s7_ap5, r_s7_ap2;
    logic signed [15:0] r_s7_tc;
    logic signed [31:0] r_s7_fine;
    logic [19:0]        r_s7_adcp;

    assign w_aap6 = $signed({1'b0, r_s6_aa}) * w_p6;
    assign w_aap3 = $signed({1'b0, r_s6_aa}) * w_p3;

    always_ff @(posedge i_clk) begin
        r_s7_aap6 <= w_aap6[63:0];
        r_s7_aap3 <= w_aap3[63:0];
        r_s7_ap5  <= r_s6_ap5;
        r_s7_ap2  <= r_s6_ap2;
        r_s7_tc   <= r_s6_tc;
        r_s7_fine <= r_s6_fine;
        r_s7_adcp <= r_s6_adcp;
    end

    logic signed [63:0] r_s8_b;
    logic signed [55:0] r_s8_a2;
    logic signed [15:0] r_s8_tc;
    logic signed [31:0] r_s8_fine;
    logic [19:0]        r_s8_adcp;

    always_ff @(posedge i_clk) begin
        r_s8_b    <= r_s7_aap6 + (64'(r_s7_ap5) <<< 17) + (64'(w_p4) <<< 35);
        r_s8_a2   <= 56'($signed(r_s7_aap3[63:8])) + (56'(r_s7_ap2) <<< 12)
                     + (56'sd1 <<< 47);
        r_s8_tc   <= r_s7_tc;
        r_s8_fine <= r_s7_fine;
        r_s8_adcp <= r_s7_adcp;
    end

    logic signed [22:0] w_a2_hi;
    logic signed [39:0] r_s9_hp;
    logic [48:0]        r_s9_lp;
    logic signed [63:0] r_s9_b;
    logic signed [15:0] r_s9_tc;
    logic signed [31:0] r_s9_fine;
    logic [19:0]        r_s9_adcp;

    assign w_a2_hi = r_s8_a2[55:33];

    always_ff @(posedge i_clk) begin
        r_s9_hp   <= w_a2_hi * $signed({1'b0, w_p1});
        r_s9_lp   <= r_s8_a2[32:0] * w_p1;
        r_s9_b    <= r_s8_b;
        r_s9_tc   <= r_s8_tc;
        r_s9_fine <= r_s8_fine;
        r_s9_adcp <= r_s8_adcp;
    end

    logic [20:0]        w_pr;
    logic signed [40:0] r_s10_div;
    logic signed [63:0] r_s10_num;
    logic signed [15:0] r_s10_tc;
    logic signed [31:0] r_s10_fine;

    assign w_pr = 21'h100000 - {1'b0, r_s9_adcp};

    always_ff @(posedge i_clk) begin
        r_s10_div  <= 41'(r_s9_hp) + 41'($signed({1'b0, r_s9_lp[48:33]}));
        r_s10_num  <= $signed({12'd0, w_pr, 31'd0}) - r_s9_b;
        r_s10_tc   <= r_s9_tc;
        r_s10_fine <= r_s9_fine;
    end

    logic [63:0]                r_s11_nmag;
    logic [ptc_pkg::DBITS-1:0]  r_s11_dmag;
    logic                       r_s11_neg;
    logic                       r_s11_zero;
    logic signed [15:0]         r_s11_tc;
    logic signed [31:0]         r_s11_fine;

    always_ff @(posedge i_clk) begin
        r_s11_nmag <= r_s10_num[63] ? 64'(-r_s10_num) : 64'(r_s10_num);
        r_s11_dmag <= r_s10_div[40] ? 41'(-r_s10_div) : 41'(r_s10_div);
        r_s11_neg  <= r_s10_num[63] ^ r_s10_div[40];
        r_s11_zero <= (r_s10_div == 41'sd0);
        r_s11_tc   <= r_s10_tc;
        r_s11_fine <= r_s10_fine;
    end

    logic [ptc_pkg::NBITS-1:0]  r_s12_n;
    logic [ptc_pkg::DBITS-1:0]  r_s12_dmag;
    logic                       r_s12_neg;
    logic                       r_s12_zero;
    logic signed [15:0]         r_s12_tc;
    logic signed [31:0]         r_s12_fine;

    always_ff @(posedge i_clk) begin
        r_s12_n    <= ptc_pkg::NBITS'(r_s11_nmag) * ptc_pkg::NBITS'(ptc_pkg::PR_SCALE);
        r_s12_dmag <= r_s11_dmag;
        r_s12_neg  <= r_s11_neg;
        r_s12_zero <= r_s11_zero;
        r_s12_tc   <= r_s11_tc;
        r_s12_fine <= r_s11_fine;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_sv <= '0;
        end else begin
            r_sv <= {r_sv[10:0], start && !busy};
        end
    end

    // Divider row: one quotient bit per cell.
    ptc_pkg::t_div_slot w_head;
    ptc_pkg::t_div_slot r_s13;
    ptc_pkg::t_div_slot w_chain [ptc_pkg::QBITS+1];

    always_comb begin
        w_head      = '0;
        w_head.vld  = r_sv[11];
        w_head.rem  = {1'b0, r_s12_n[ptc_pkg::NBITS-1:ptc_pkg::QBITS]};
        w_head.nlow = r_s12_n[ptc_pkg::QBITS-1:0];
        w_head.dmag = r_s12_dmag;
        w_head.neg  = r_s12_neg;
        w_head.zero = r_s12_zero;
        w_head.ovf  = ({1'b0, r_s12_n[ptc_pkg::NBITS-1:ptc_pkg::QBITS]} >= r_s12_dmag);
        w_head.tc   = r_s12_tc;
        w_head.fine = r_s12_fine;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s13 <= '0;
        end else begin
            r_s13 <= w_head;
        end
    end

    assign w_chain[0] = r_s13;

    for (genvar g = 0; g < ptc_pkg::QBITS; g++) begin : g_cell
        ptc_div_cell u_cell (
            .i_clk  (i_clk),
            .i_rst_n(i_rst_n),
            .i_slot (w_chain[g]),
            .o_slot (w_chain[g+1])
        );
    end

    // Pressure back end.
    ptc_pkg::t_div_slot  w_tail;
    logic [2:0]          r_pv;
    logic [35:0]         w_qmag;
    logic signed [36:0]  r_p1_pr;
    logic                r_p1_zero;
    logic signed [15:0]  r_p1_tc;
    logic signed [31:0]  r_p1_fine;

    assign w_tail = w_chain[ptc_pkg::QBITS];
    assign w_qmag = (w_tail.ovf || w_tail.quo[35]) ? 36'h8_0000_0000 : w_tail.quo;

    always_ff @(posedge i_clk) begin
        r_p1_pr   <= w_tail.neg ? -$signed({1'b0, w_qmag}) : $signed({1'b0, w_qmag});
        r_p1_zero <= w_tail.zero;
        r_p1_tc   <= w_tail.tc;
        r_p1_fine <= w_tail.fine;
    end

    logic signed [23:0] w_prs;
    logic signed [47:0] r_p2_sq;
    logic signed [52:0] r_p2_p8pr;
    logic signed [36:0] r_p2_pr;
    logic               r_p2_zero;
    logic signed [15:0] r_p2_tc;
    logic signed [31:0] r_p2_fine;

    assign w_prs = r_p1_pr[36:13];

    always_ff @(posedge i_clk) begin
        r_p2_sq   <= w_prs * w_prs;
        r_p2_p8pr <= w_p8 * r_p1_pr;
        r_p2_pr   <= r_p1_pr;
        r_p2_zero <= r_p1_zero;
        r_p2_tc   <= r_p1_tc;
        r_p2_fine <= r_p1_fine;
    end

    logic signed [63:0] w_p9sq;
    logic signed [38:0] r_p3_a;
    logic signed [33:0] r_p3_b;
    logic signed [36:0] r_p3_pr;
    logic               r_p3_zero;
    logic signed [15:0] r_p3_tc;
    logic signed [31:0] r_p3_fine;

    assign w_p9sq = r_p2_sq * w_p9;

    always_ff @(posedge i_clk) begin
        r_p3_a    <= w_p9sq[63:25];
        r_p3_b    <= r_p2_p8pr[52:19];
        r_p3_pr   <= r_p2_pr;
        r_p3_zero <= r_p2_zero;
        r_p3_tc   <= r_p2_tc;
        r_p3_fine <= r_p2_fine;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pv <= '0;
        end else begin
            r_pv <= {r_pv[1:0], w_tail.vld};
        end
    end

    logic signed [39:0]  w_sum;
    logic signed [39:0]  w_fin;
    logic [31:0]         w_pq;
    ptc_pkg::t_out_item  r_out;
    logic                r_done;

    assign w_sum = 40'(r_p3_pr) + 40'(r_p3_a) + 40'(r_p3_b);
    assign w_fin = 40'($signed(w_sum[39:8])) + 40'($signed({w_p7, 4'd0}));

    always_comb begin
        if (r_p3_zero || w_fin < 40'sd0) begin
            w_pq = 32'd0;
        end else if (w_fin > 40'sh00_ffff_ffff) begin
            w_pq = 32'hffff_ffff;
        end else begin
            w_pq = w_fin[31:0];
        end
    end

    always_ff @(posedge i_clk) begin
        r_out.temperature_centi <= r_p3_tc;
        r_out.fine_temperature  <= r_p3_fine;
        r_out.pressure_q24_8    <= w_pq;
        r_out.pressure_valid    <= !r_p3_zero;
        if (!i_rst_n) begin
            r_done <= 1'b0;
        end else begin
            r_done <= r_pv[2];
        end
    end

    assign o_done = r_done;
    assign o_item = r_out;

`ifndef SYNTHESIS
    a_done_has_source: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_done |-> $past(start, LAT))
        else $error("Result strobe without a matching input transfer.");
    a_start_gives_done: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (start && !busy) |-> ##LAT o_done)
        else $error("Input transfer produced no result.");
    a_invalid_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_done && !o_item.pressure_valid) |-> (o_item.pressure_q24_8 == 32'd0))
        else $error("Invalid pressure result is not zero.");
`endif

endmodule

>>> rtl/ptc_div_cell.sv
module ptc_div_cell (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  ptc_pkg::t_div_slot  i_slot,
    output ptc_pkg::t_div_slot  o_slot
);

    logic [ptc_pkg::DBITS:0] w_part;
    logic [ptc_pkg::DBITS:0] w_diff;
    logic                    w_ge;
    ptc_pkg::t_div_slot      n_slot;
    ptc_pkg::t_div_slot      r_slot;

    assign w_part = {i_slot.rem, i_slot.nlow[ptc_pkg::QBITS-1]};
    assign w_diff = w_part - {1'b0, i_slot.dmag};
    assign w_ge   = (w_part >= {1'b0, i_slot.dmag});

    always_comb begin
        n_slot      = i_slot;
        n_slot.rem  = w_ge ? w_diff[ptc_pkg::DBITS-1:0] : w_part[ptc_pkg::DBITS-1:0];
        n_slot.nlow = {i_slot.nlow[ptc_pkg::QBITS-2:0], 1'b0};
        n_slot.quo  = {i_slot.quo[ptc_pkg::QBITS-2:0], w_ge};
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_slot <= '0;
        end else begin
            r_slot <= n_slot;
        end
    end

    assign o_slot = r_slot;

`ifndef SYNTHESIS
    a_rem_below_div: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_slot.vld && !r_slot.ovf) |-> (r_slot.rem < r_slot.dmag))
        else $error("Partial remainder reached the divisor.");
`endif

endmodule

>>> tb/tb_pressure_temperature_compensation_core.sv
module tb_pressure_temperature_compensation_core;

    typedef logic signed [127:0] t_wide;

    typedef struct {
        logic [19:0]         rt;
        logic [19:0]         rp;
        bit                  typed;
        ptc_pkg::t_out_item  want;
    } t_stim_row;

    localparam int LATENCY_WAIT = 64;
    localparam int CYCLE_LIMIT  = 400000;

    logic                i_clk = 1'b0;
    logic                i_rst_n = 1'b0;
    logic                start = 1'b0;
    logic                busy;
    ptc_pkg::t_in_item   i_item = '0;
    logic                o_done;
    ptc_pkg::t_out_item  o_item;
    logic                psel = 1'b0;
    logic                penable = 1'b0;
    logic                pwrite = 1'b0;
    logic [4:0]          paddr = '0;
    logic [63:0]         pwdata = '0;
    logic [63:0]         prdata;
    logic                pready;

    logic [47:0] cal_temp;
    logic [63:0] cal_a;
    logic [63:0] cal_b;
    logic [15:0] cal_c;

    ptc_pkg::t_out_item  pending_results[$];
    int                  mismatches = 0;
    int                  cycles = 0;

    pressure_temperature_compensation_core DUT (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .start(start), .busy(busy), .i_item(i_item),
        .o_done(o_done), .o_item(o_item), .psel(psel), .penable(penable), .pwrite(pwrite),
        .paddr(paddr), .pwdata(pwdata), .prdata(prdata), .pready(pready)
    );

    always #2 i_clk = ~i_clk;

    function automatic ptc_pkg::t_out_item compensate(ptc_pkg::t_in_item it);
        t_wide one, adt, adp, t1, t2, t3, p1, p2, p3, p4, p5, p6, p7, p8, p9;
        t_wide a, b, dt, fine, tc, pr, num, dv, hi, lo;
        ptc_pkg::t_out_item r;
        one = 1;
        adt = $signed({108'd0, it.raw_temperature});
        adp = $signed({108'd0, it.raw_pressure});
        t1 = $signed({112'd0, cal_temp[15:0]});
        t2 = $signed(cal_temp[31:16]);
        t3 = $signed(cal_temp[47:32]);
        p1 = $signed({112'd0, cal_a[15:0]});
        p2 = $signed(cal_a[31:16]);
        p3 = $signed(cal_a[47:32]);
        p4 = $signed(cal_a[63:48]);
        p5 = $signed(cal_b[15:0]);
        p6 = $signed(cal_b[31:16]);
        p7 = $signed(cal_b[47:32]);
        p8 = $signed(cal_b[63:48]);
        p9 = $signed(cal_c);

        a = (((adt >>> 3) - t1 * 2) * t2) >>> 11;
        dt = (adt >>> 4) - t1;
        b = (((dt * dt) >>> 12) * t3) >>> 14;
        fine = a + b;
        tc = (fine * 5 + 128) >>> 8;
        if (tc > 32767) tc = 32767;
        if (tc < -32768) tc = -32768;
        r.temperature_centi = tc[15:0];
        r.fine_temperature = fine[31:0];

        a = fine - 128000;
        b = a * a * p6 + a * p5 * 131072 + p4 * (one <<< 35);
        a = ((a * a * p3) >>> 8) + a * p2 * 4096;
        a = (one <<< 47) + a;
        hi = a >>> 33;
        lo = a - (hi <<< 33);
        dv = hi * p1 + ((lo * p1) >>> 33);
        if (dv == 0) begin
            r.pressure_q24_8 = '0;
            r.pressure_valid = 1'b0;
        end else begin
            pr = 1048576 - adp;
            num = (pr <<< 31) - b;
            hi = num / dv;
            lo = num % dv;
            if (hi >= (one <<< 24)) begin
                pr = one <<< 35;
            end else if (hi <= -(one <<< 24)) begin
                pr = -(one <<< 35);
            end else begin
                pr = hi * 3125 + (lo * 3125) / dv;
                if (pr > (one <<< 35)) pr = one <<< 35;
                if (pr < -(one <<< 35)) pr = -(one <<< 35);
            end
            a = (p9 * (pr >>> 13) * (pr >>> 13)) >>> 25;
            b = (p8 * pr) >>> 19;
            pr = ((pr + a + b) >>> 8) + p7 * 16;
            if (pr < 0) r.pressure_q24_8 = '0;
            else if (pr > 64'hFFFFFFFF) r.pressure_q24_8 = 32'hFFFFFFFF;
            else r.pressure_q24_8 = pr[31:0];
            r.pressure_valid = 1'b1;
        end
        return r;
    endfunction

    always @(posedge i_clk) begin
        ptc_pkg::t_out_item want;
        cycles <= cycles + 1;
        if (cycles > CYCLE_LIMIT) begin
            $display("timeout after %0d cycles", cycles);
            $display("== FAIL ==");
            $finish;
        end
        if (i_rst_n && start && !busy) pending_results.push_back(compensate(i_item));
        if (i_rst_n && o_done) begin
            if (pending_results.size() == 0) begin
                mismatches++;
                if (mismatches <= 10) $display("unexpected result %p", o_item);
            end else begin
                want = pending_results.pop_front();
                if (o_item.temperature_centi !== want.temperature_centi
                    || o_item.fine_temperature !== want.fine_temperature
                    || o_item.pressure_q24_8 !== want.pressure_q24_8
                    || o_item.pressure_valid !== want.pressure_valid) begin
                    mismatches++;
                    if (mismatches <= 10)
                        $display("mismatch: expected %p, got %p", want, o_item);
                end
            end
        end
    end

    task automatic write_reg(input logic [1:0] idx, input logic [63:0] val);
        @(negedge i_clk);
        psel <= 1'b1;
        penable <= 1'b0;
        pwrite <= 1'b1;
        paddr <= {idx, 3'b000};
        pwdata <= val;
        @(negedge i_clk);
        penable <= 1'b1;
        @(posedge i_clk);
        while (!pready) @(posedge i_clk);
        case (idx)
            ptc_pkg::REG_TEMP_CAL: cal_temp = val[47:0];
            ptc_pkg::REG_CAL_A:    cal_a = val;
            ptc_pkg::REG_CAL_B:    cal_b = val;
            ptc_pkg::REG_CAL_C:    cal_c = val[15:0];
            default: ;
        endcase
        @(negedge i_clk);
        psel <= 1'b0;
        penable <= 1'b0;
        pwrite <= 1'b0;
    endtask

    task automatic drain_results();
        start <= 1'b0;
        @(negedge i_clk);
        while (pending_results.size() != 0) @(negedge i_clk);
        repeat (LATENCY_WAIT) @(negedge i_clk);
    endtask

    task automatic load_cal(input logic [47:0] tw, input logic [63:0] aw,
                            input logic [63:0] bw, input logic [15:0] cw);
        drain_results();
        write_reg(ptc_pkg::REG_TEMP_CAL, {16'd0, tw});
        write_reg(ptc_pkg::REG_CAL_A, aw);
        write_reg(ptc_pkg::REG_CAL_B, bw);
        write_reg(ptc_pkg::REG_CAL_C, {48'd0, cw});
    endtask

    task automatic send_sample(input logic [19:0] rt, input logic [19:0] rp);
        int gap;
        gap = ($urandom_range(0, 9) == 0) ? $urandom_range(5, 40) : $urandom_range(0, 2);
        if ($urandom_range(0, 3) == 0) gap = 0;
        if (gap > 0) begin
            start <= 1'b0;
            repeat (gap) @(negedge i_clk);
        end
        start <= 1'b1;
        i_item <= '{raw_temperature: rt, raw_pressure: rp};
        @(posedge i_clk);
        while (busy) @(posedge i_clk);
        @(negedge i_clk);
    endtask

    task automatic random_samples(input int n);
        logic [19:0] rt, rp;
        for (int k = 0; k < n; k++) begin
            if ($urandom_range(0, 3) != 0) begin
                rt = 20'(400000 + $urandom_range(0, 250000));
                rp = 20'(250000 + $urandom_range(0, 300000));
            end else begin
                rt = 20'($urandom);
                rp = 20'($urandom);
            end
            send_sample(rt, rp);
            if (k == n / 2 && $urandom_range(0, 1) == 0) drain_results();
        end
    endtask

    t_stim_row           rows[$];
    ptc_pkg::t_out_item  zero_div;
    logic [47:0]         typ_t;
    logic [63:0]         typ_a, typ_b;

    initial begin
        zero_div = '{temperature_centi: 16'sd0, fine_temperature: 32'sd0,
                     pressure_q24_8: 32'd0, pressure_valid: 1'b0};
        cal_temp = '0;
        cal_a = '0;
        cal_b = '0;
        cal_c = '0;
        typ_t = {16'hFC18, 16'd26435, 16'd27504};
        typ_a = {16'd2855, 16'd3024, 16'hD643, 16'd36477};
        typ_b = {16'hC6F8, 16'd15500, 16'hFFF9, 16'd140};

        rows.push_back('{20'd0, 20'd0, 1'b1, zero_div});
        rows.push_back('{20'hFFFFF, 20'hFFFFF, 1'b1, zero_div});
        rows.push_back('{20'd0, 20'hFFFFF, 1'b1, zero_div});
        rows.push_back('{20'hFFFFF, 20'd0, 1'b1, zero_div});
        rows.push_back('{20'h55555, 20'hAAAAA, 1'b1, zero_div});

        repeat (8) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        foreach (rows[r]) begin
            send_sample(rows[r].rt, rows[r].rp);
            if (rows[r].typed)
                pending_results[pending_results.size() - 1] = rows[r].want;
        end

        load_cal(typ_t, typ_a, typ_b, 16'd6000);
        send_sample(20'd519888, 20'd415148);
        send_sample(20'd0, 20'd0);
        send_sample(20'hFFFFF, 20'hFFFFF);
        send_sample(20'd0, 20'hFFFFF);
        send_sample(20'hFFFFF, 20'd0);
        send_sample(20'hAAAAA, 20'h55555);
        send_sample(20'd440000, 20'd1);
        send_sample(20'd600000, 20'd1048575);

        load_cal(typ_t, {typ_a[63:16], 16'd0}, typ_b, 16'd6000);
        send_sample(20'd519888, 20'd415148);
        send_sample(20'hFFFFF, 20'd0);

        load_cal(48'hFFFFFFFFFFFF, 64'hFFFFFFFFFFFFFFFF, 64'hFFFFFFFFFFFFFFFF, 16'hFFFF);
        send_sample(20'd0, 20'd0);
        send_sample(20'hFFFFF, 20'hFFFFF);
        load_cal({16'h7FFF, 16'h8000, 16'd0}, {16'h7FFF, 16'h7FFF, 16'h8000, 16'hFFFF},
                 {16'h7FFF, 16'h8000, 16'h7FFF, 16'h8000}, 16'h8000);
        send_sample(20'd0, 20'd0);
        send_sample(20'hFFFFF, 20'hFFFFF);
        send_sample(20'd524288, 20'd1);

        load_cal(typ_t, typ_a, typ_b, 16'd6000);
        random_samples(400);
        load_cal(48'({$urandom, $urandom}), {$urandom, $urandom}, {$urandom, $urandom},
                 16'($urandom));
        random_samples(150);
        load_cal(48'hFFFFFFFFFFFF, 64'hFFFFFFFFFFFFFFFF, 64'hFFFFFFFFFFFFFFFF, 16'hFFFF);
        random_samples(100);
        load_cal(typ_t ^ 48'($urandom_range(0, 255)), typ_a ^ 64'($urandom_range(0, 255)),
                 typ_b ^ 64'($urandom_range(0, 255)), 16'($urandom_range(0, 65535)));
        random_samples(200);
        load_cal('0, '0, '0, '0);
        random_samples(50);
        load_cal(48'({$urandom, $urandom}), {$urandom, $urandom}, {$urandom, $urandom},
                 16'($urandom));
        random_samples(100);

        drain_results();
        if (mismatches == 0) begin
            $display("== PASS ==");
        end else begin
            $display("%0d mismatches", mismatches);
            $display("== FAIL ==");
        end
        $finish;
    end

endmodule
